// ===== sv/aam_pkg.sv =====
package aam_pkg;

  // Port widths
  localparam int X_W           = 18;
  localparam int OUT_W         = 19;
  localparam int FRAC_BITS_DEF = 16;

  // Internal fixed point: 30 fractional bits
  localparam int QF     = 30;
  localparam int XQ_W   = QF + 1;          // |x| clamped to 1.0
  localparam int ROOT_W = QF + 1;          // sqrt result, at most 1.0
  localparam int RAD_W  = 2 * QF + 1;      // sqrt radicand, at most 2^60
  localparam int MAG_W  = QF + 2;          // magnitude of a Horner partial, below 2.0
  localparam int PROD_W = MAG_W + XQ_W;
  localparam int ACC_W  = MAG_W + 1;       // signed Horner accumulator
  localparam int ANG_W  = ACC_W + 1;       // signed angle before output rounding
  localparam int POLY_DEG = 7;

  localparam logic [XQ_W-1:0] Q_ONE = XQ_W'(64'd1 << QF);
  localparam logic signed [ANG_W-1:0] Q_PI      = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0] Q_HALF_PI = 34'sd1686629713;

  // Command codes
  localparam logic CMD_ASIN = 1'b0;
  localparam logic CMD_ACOS = 1'b1;

  // Coefficient magnitudes: decimal constants (x 1e-10) rounded to nearest Q.30
  localparam logic [63:0] DEC_SCALE = 64'd1073741824;
  localparam logic [63:0] DEC_HALF  = 64'd5000000000;
  localparam logic [63:0] DEC_DIV   = 64'd10000000000;
  localparam logic [63:0] C0_MAG = (64'd12624911 * DEC_SCALE + DEC_HALF) / DEC_DIV;
  localparam logic [63:0] C1_MAG = (64'd66700901 * DEC_SCALE + DEC_HALF) / DEC_DIV;
  localparam logic [63:0] C2_MAG = (64'd170881256 * DEC_SCALE + DEC_HALF) / DEC_DIV;
  localparam logic [63:0] C3_MAG = (64'd308918810 * DEC_SCALE + DEC_HALF) / DEC_DIV;
  localparam logic [63:0] C4_MAG = (64'd501743046 * DEC_SCALE + DEC_HALF) / DEC_DIV;
  localparam logic [63:0] C5_MAG = (64'd889789874 * DEC_SCALE + DEC_HALF) / DEC_DIV;
  localparam logic [63:0] C6_MAG = (64'd2145988016 * DEC_SCALE + DEC_HALF) / DEC_DIV;
  localparam logic [63:0] C7_MAG = (64'd15707963050 * DEC_SCALE + DEC_HALF) / DEC_DIV;

  typedef struct packed {
    logic [RAD_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic              neg;
    logic [PROD_W-1:0] prod;
  } mul_t;

  // Horner coefficients, highest degree first
  function automatic logic signed [ACC_W-1:0] poly_coef(input logic [2:0] idx);
    logic signed [ACC_W-1:0] c;
    case (idx)
      3'd0:    c = -$signed({1'b0, C0_MAG[MAG_W-1:0]});
      3'd1:    c =  $signed({1'b0, C1_MAG[MAG_W-1:0]});
      3'd2:    c = -$signed({1'b0, C2_MAG[MAG_W-1:0]});
      3'd3:    c =  $signed({1'b0, C3_MAG[MAG_W-1:0]});
      3'd4:    c = -$signed({1'b0, C4_MAG[MAG_W-1:0]});
      3'd5:    c =  $signed({1'b0, C5_MAG[MAG_W-1:0]});
      3'd6:    c = -$signed({1'b0, C6_MAG[MAG_W-1:0]});
      3'd7:    c =  $signed({1'b0, C7_MAG[MAG_W-1:0]});
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/asin_acos_minimax_unit.sv =====
// Channel  Handshake            Payload
// in       in_valid / in_stall  cmd (0 asin, 1 acos), x_in (signed, FRAC_BITS frac bits)
// out      out_valid/ out_stall angle_out (signed radians, FRAC_BITS frac bits)
//
// One item enters per cycle while in_stall is low.
// The square root sets the pipeline length: one result bit per stage, 31 stages,
// with the Horner chain (7 multiply / add pairs) running beside it.
// rst clears the valid bits only; payload registers carry no reset.
// The whole pipeline holds while a result sits on the output and out_stall is
// high; in_stall follows that condition, so nothing is dropped or repeated.
module asin_acos_minimax_unit #(
  parameter int FRAC_BITS = aam_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              cmd,
  input  logic signed [aam_pkg::X_W-1:0]    x_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [aam_pkg::OUT_W-1:0]  angle_out
);

  // Fixed-point alignment between the ports and the Q.30 datapath
  localparam int SH       = aam_pkg::QF - FRAC_BITS;
  localparam int XS_W     = (aam_pkg::X_W + SH > aam_pkg::XQ_W) ?
                            aam_pkg::X_W + SH : aam_pkg::XQ_W;
  localparam int RND_W    = aam_pkg::ANG_W + 1;

  // Stage map
  localparam int SQ_STG   = aam_pkg::ROOT_W;        // last square root bit stage
  localparam int ROOT_STG = SQ_STG + 1;             // rounded root
  localparam int HX_LAST  = 2 * aam_pkg::POLY_DEG - 2; // last xq tap used
  localparam int HZ_DONE  = 2 * aam_pkg::POLY_DEG;  // polynomial finished
  localparam int FM_STG   = ROOT_STG + 1;           // acc * root
  localparam int R_STG    = FM_STG + 1;             // rounded r
  localparam int ANG_STG  = R_STG + 1;              // angle
  localparam int LAST     = ANG_STG + 1;            // output register

  localparam logic [RND_W-1:0] RND_HALF = RND_W'(1) << (SH - 1);
  localparam logic [RND_W-1:0] OUT_MAX  = RND_W'((1 << (aam_pkg::OUT_W - 1)) - 1);
  localparam logic [RND_W-1:0] OUT_MINM = RND_W'(1 << (aam_pkg::OUT_W - 1));

  // ---------------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------------

  // Unsigned magnitude product; sign travels beside it
  function automatic aam_pkg::mul_t mul_mag(input logic signed [aam_pkg::ACC_W-1:0] a,
                                           input logic [aam_pkg::XQ_W-1:0] b);
    aam_pkg::mul_t               m;
    logic [aam_pkg::ACC_W-1:0]   a_u;
    logic [aam_pkg::MAG_W-1:0]   a_m;
    a_u    = a[aam_pkg::ACC_W-1] ? aam_pkg::ACC_W'(-a) : aam_pkg::ACC_W'(a);
    a_m    = a_u[aam_pkg::MAG_W-1:0];
    m.neg  = a[aam_pkg::ACC_W-1];
    m.prod = aam_pkg::PROD_W'(a_m) * aam_pkg::PROD_W'(b);
    return m;
  endfunction

  // Round a Q.60 product to Q.30, halves away from zero
  function automatic logic signed [aam_pkg::ACC_W-1:0] round_q(input aam_pkg::mul_t m);
    logic [aam_pkg::PROD_W:0]       sum;
    logic [aam_pkg::MAG_W-1:0]      q;
    logic signed [aam_pkg::ACC_W-1:0] r;
    sum = {1'b0, m.prod} + ((aam_pkg::PROD_W + 1)'(1) << (aam_pkg::QF - 1));
    q   = sum[aam_pkg::QF+aam_pkg::MAG_W-1:aam_pkg::QF];
    r   = $signed({1'b0, q});
    return m.neg ? -r : r;
  endfunction

  // One restoring square root step for result bit k
  function automatic aam_pkg::sq_t sqrt_step(input aam_pkg::sq_t s, input int k);
    aam_pkg::sq_t                o;
    logic [aam_pkg::RAD_W:0]     trial;
    trial = ((aam_pkg::RAD_W + 1)'(s.root) << (k + 1)) + ((aam_pkg::RAD_W + 1)'(1) << (2 * k));
    o = s;
    if ({1'b0, s.rem} >= trial) begin
      o.rem  = s.rem - trial[aam_pkg::RAD_W-1:0];
      o.root = s.root | (aam_pkg::ROOT_W'(1) << k);
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Flow control: advance everything unless a result is held at the output
  // ---------------------------------------------------------------------------
  logic            adv;
  logic [LAST:0]   vld;
  logic [ANG_STG-1:0] cmd_d;
  logic [ANG_STG-1:0] nneg_d;

  assign adv       = !(vld[LAST] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], in_valid};
    end
  end

  // Sign and command ride along with the data
  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_d  <= {cmd_d[ANG_STG-2:0], cmd};
      nneg_d <= {nneg_d[ANG_STG-2:0], !x_in[aam_pkg::X_W-1]};
    end
  end

  // ---------------------------------------------------------------------------
  // Front: |x| to Q.30, clamp at 1.0, form the radicand (1 - |x|) << 30
  // ---------------------------------------------------------------------------
  logic [aam_pkg::X_W-1:0]  x_bits;
  logic [aam_pkg::X_W-1:0]  ax;
  logic [XS_W-1:0]          xs;
  logic [aam_pkg::XQ_W-1:0] xq_f;

  always_comb begin
    x_bits = x_in;
    ax     = x_bits[aam_pkg::X_W-1] ? (~x_bits + 1'b1) : x_bits;
    xs     = XS_W'(ax) << SH;
    xq_f   = (xs > XS_W'(aam_pkg::Q_ONE)) ? aam_pkg::Q_ONE : xs[aam_pkg::XQ_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Square root: stage 0 holds the radicand, stages 1..31 each settle one bit
  // ---------------------------------------------------------------------------
  aam_pkg::sq_t            sq      [0:SQ_STG];
  wire aam_pkg::sq_t       sq_next [0:SQ_STG];
  logic [aam_pkg::ROOT_W-1:0] root_fin;

  assign sq_next[0] = '{rem:  {aam_pkg::Q_ONE - xq_f, aam_pkg::QF'(0)},
                        root: '0};

  for (genvar j = 1; j <= SQ_STG; j++) begin : g_sqrt
    assign sq_next[j] = sqrt_step(sq[j-1], SQ_STG - j);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j <= SQ_STG; j++) begin
        sq[j] <= sq_next[j];
      end
      // Round to nearest: bump when the remainder exceeds the floor root
      root_fin <= sq[SQ_STG].root +
                  aam_pkg::ROOT_W'(sq[SQ_STG].rem > aam_pkg::RAD_W'(sq[SQ_STG].root));
    end
  end

  // ---------------------------------------------------------------------------
  // Horner chain: step i multiplies at stage 2i-1 and adds at stage 2i
  // ---------------------------------------------------------------------------
  logic [aam_pkg::XQ_W-1:0]          xq_d    [0:HX_LAST];
  aam_pkg::mul_t                     hm      [1:aam_pkg::POLY_DEG];
  wire aam_pkg::mul_t                hm_next [1:aam_pkg::POLY_DEG];
  logic signed [aam_pkg::ACC_W-1:0]  ha      [1:aam_pkg::POLY_DEG];
  wire logic signed [aam_pkg::ACC_W-1:0] ha_next [1:aam_pkg::POLY_DEG];
  logic signed [aam_pkg::ACC_W-1:0]  acc_dly [HZ_DONE+1:ROOT_STG];

  for (genvar i = 1; i <= aam_pkg::POLY_DEG; i++) begin : g_horner
    if (i == 1) begin : g_first
      assign hm_next[i] = mul_mag(aam_pkg::poly_coef(3'(0)), xq_d[0]);
    end else begin : g_rest
      assign hm_next[i] = mul_mag(ha[i-1], xq_d[2*i-2]);
    end
    assign ha_next[i] = round_q(hm[i]) + aam_pkg::poly_coef(3'(i));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xq_d[0] <= xq_f;
      for (int j = 1; j <= HX_LAST; j++) begin
        xq_d[j] <= xq_d[j-1];
      end
      for (int i = 1; i <= aam_pkg::POLY_DEG; i++) begin
        hm[i] <= hm_next[i];
        ha[i] <= ha_next[i];
      end
      // Hold the polynomial until the root catches up
      acc_dly[HZ_DONE+1] <= ha[aam_pkg::POLY_DEG];
      for (int j = HZ_DONE + 2; j <= ROOT_STG; j++) begin
        acc_dly[j] <= acc_dly[j-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Back end: r = p(|x|) * root, angle by command and sign, round to output
  // ---------------------------------------------------------------------------
  aam_pkg::mul_t                    fm;
  logic signed [aam_pkg::ACC_W-1:0] r_q;
  logic signed [aam_pkg::ANG_W-1:0] rx;
  logic signed [aam_pkg::ANG_W-1:0] ang_next;
  logic signed [aam_pkg::ANG_W-1:0] ang_q;
  logic [aam_pkg::ANG_W-1:0]        ang_mag;
  logic [RND_W-1:0]                 ang_rnd;
  logic signed [aam_pkg::OUT_W-1:0] out_next;

  always_comb begin
    rx = aam_pkg::ANG_W'(r_q);
    case (cmd_d[R_STG])
      aam_pkg::CMD_ASIN: ang_next = nneg_d[R_STG] ? aam_pkg::Q_HALF_PI - rx
                                                  : rx - aam_pkg::Q_HALF_PI;
      aam_pkg::CMD_ACOS: ang_next = nneg_d[R_STG] ? rx : aam_pkg::Q_PI - rx;
      default:           ang_next = '0;
    endcase
  end

  // Round magnitude half away from zero, then saturate to the port range
  always_comb begin
    ang_mag = ang_q[aam_pkg::ANG_W-1] ? aam_pkg::ANG_W'(-ang_q) : aam_pkg::ANG_W'(ang_q);
    ang_rnd = (RND_W'(ang_mag) + RND_HALF) >> SH;
    if (!ang_q[aam_pkg::ANG_W-1]) begin
      out_next = (ang_rnd > OUT_MAX) ? OUT_MAX[aam_pkg::OUT_W-1:0]
                                     : ang_rnd[aam_pkg::OUT_W-1:0];
    end else begin
      out_next = (ang_rnd > OUT_MINM) ? OUT_MINM[aam_pkg::OUT_W-1:0]
                                      : -ang_rnd[aam_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fm        <= mul_mag(acc_dly[ROOT_STG], root_fin);
      r_q       <= round_q(fm);
      ang_q     <= ang_next;
      angle_out <= out_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------

  // Floor square root leaves a remainder of at most twice the root
  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    vld[SQ_STG] |-> (sq[SQ_STG].rem <= aam_pkg::RAD_W'({sq[SQ_STG].root, 1'b0})))
    else $error("square root remainder out of range");

  // The polynomial stays positive over the whole clamped argument range
  a_poly_pos: assert property (@(posedge clk) disable iff (rst)
    vld[HZ_DONE] |-> (ha[aam_pkg::POLY_DEG] > 0))
    else $error("Horner result not positive");

  // A held output freezes every valid bit in the pipeline
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[LAST] && out_stall) |=> $stable(vld))
    else $error("pipeline moved while output held");

endmodule
